FILE: rtl/ptc_pkg.sv
// Shared types and constants for the pulse train capture block.
`timescale 1ns / 1ps
`default_nettype none
package ptc_pkg;

  localparam int CfgIdxW = 2;

  localparam logic [CfgIdxW-1:0] REG_RESET_TICKS   = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_RESET_LEVEL   = 2'd1;
  localparam logic [CfgIdxW-1:0] REG_PULSE_LIMIT   = 2'd2;
  localparam logic [CfgIdxW-1:0] REG_TIMEOUT_TICKS = 2'd3;

  localparam logic [8:0]  PULSE_LIMIT_RESET   = 9'd256;
  localparam logic [31:0] TIMEOUT_TICKS_RESET = 32'd1000000;

  localparam logic OP_TICK  = 1'b0;
  localparam logic OP_START = 1'b1;

  typedef struct packed {
    logic [31:0] reset_ticks;
    logic        reset_level;
    logic [8:0]  pulse_limit;
    logic [31:0] timeout_ticks;
  } ptc_cfg_t;

  typedef struct packed {
    logic        drive_enable;
    logic        drive_level;
    logic        pulse_valid;
    logic [31:0] pulse_width;
    logic [7:0]  pulse_number;
    logic        done_res;
    logic        no_pulses;
  } ptc_result_t;

endpackage
`default_nettype wire

FILE: rtl/ptc_engine.sv
// Capture sequencer: phase, counters and the result of one transaction.
`timescale 1ns / 1ps
`default_nettype none
module ptc_engine import ptc_pkg::*; #(
  parameter int MAX_PULSES = 256
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        step,
  input  wire logic        opcode,
  input  wire logic        level,
  input  wire ptc_cfg_t    cfg,
  output ptc_result_t      res
);

  localparam int CntW = $clog2(MAX_PULSES + 1);

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_RESET,
    PH_ARM,
    PH_CAPTURE
  } phase_t;

  phase_t          phase, phase_next;
  logic [31:0]     reset_count, reset_count_next;
  logic [31:0]     elapsed, elapsed_next;
  logic [31:0]     since_edge, since_edge_next;
  logic            tracked_level, tracked_level_next;
  logic [CntW-1:0] pulse_count, pulse_count_next;

  logic [31:0]     limit;
  logic            level_change;

  // Limit saturates at the counter's capacity.
  assign limit = (32'(cfg.pulse_limit) > 32'(MAX_PULSES)) ? 32'(MAX_PULSES)
                                                          : 32'(cfg.pulse_limit);
  assign level_change = (level != tracked_level);

  always_comb begin
    phase_next         = phase;
    reset_count_next   = reset_count;
    elapsed_next       = elapsed;
    since_edge_next    = since_edge;
    tracked_level_next = tracked_level;
    pulse_count_next   = pulse_count;
    res                = '0;

    if (opcode == OP_START) begin
      elapsed_next     = '0;
      since_edge_next  = '0;
      pulse_count_next = '0;
      reset_count_next = '0;
      if (cfg.reset_ticks != 32'd0) begin
        phase_next       = PH_RESET;
        res.drive_enable = 1'b1;
        res.drive_level  = cfg.reset_level;
      end else begin
        phase_next = PH_ARM;
      end
    end else begin
      unique case (phase)
        PH_RESET: begin
          reset_count_next = reset_count + 32'd1;
          if (reset_count_next >= cfg.reset_ticks) begin
            phase_next = PH_ARM;
          end else begin
            res.drive_enable = 1'b1;
            res.drive_level  = cfg.reset_level;
          end
        end
        PH_ARM: begin
          tracked_level_next = level;
          elapsed_next       = '0;
          since_edge_next    = '0;
          pulse_count_next   = '0;
          if (cfg.timeout_ticks == 32'd0 || limit == 32'd0) begin
            res.done_res  = 1'b1;
            res.no_pulses = 1'b1;
            phase_next    = PH_IDLE;
          end else begin
            phase_next = PH_CAPTURE;
          end
        end
        PH_CAPTURE: begin
          elapsed_next    = elapsed + 32'd1;
          since_edge_next = since_edge + 32'd1;
          if (level_change) begin
            res.pulse_valid    = 1'b1;
            res.pulse_width    = since_edge_next;
            res.pulse_number   = 8'(pulse_count);
            since_edge_next    = '0;
            tracked_level_next = ~tracked_level;
            pulse_count_next   = pulse_count + CntW'(1);
          end
          if (elapsed_next >= cfg.timeout_ticks || 32'(pulse_count_next) >= limit) begin
            res.done_res  = 1'b1;
            res.no_pulses = (pulse_count_next == '0);
            phase_next    = PH_IDLE;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_IDLE;
      reset_count   <= '0;
      elapsed       <= '0;
      since_edge    <= '0;
      tracked_level <= 1'b0;
      pulse_count   <= '0;
    end else if (step) begin
      phase         <= phase_next;
      reset_count   <= reset_count_next;
      elapsed       <= elapsed_next;
      since_edge    <= since_edge_next;
      tracked_level <= tracked_level_next;
      pulse_count   <= pulse_count_next;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/pulse_train_capture.sv
// Top level of the pulse train capture block.
//
// Input channel (in_valid/in_ready, opcode, pin_level): one transaction per
// microsecond tick carrying the sampled pin level, or a start command.
// Every input transaction yields exactly one output transaction
// (out_valid/out_ready) with the drive controls, an optional numbered pulse
// width and the done/no_pulses flags.
// Configuration channel (cfg_valid/cfg_ready, cfg_index, cfg_data) is always
// ready; write it only while no transaction is in flight.
// A transaction accepted into the input register is processed into the output
// register and offered from there. Throughput: one transaction per cycle while
// the output is taken; the per-tick work is one increment per counter and a
// 32-bit compare per limit between the input and output registers.
// A stalled output holds its register; the input register still accepts one
// more transaction, then in_ready drops until the output is taken.
// Reset: synchronous, clears the pipeline, returns the sequencer to idle and
// loads the register defaults (pulse limit 256, timeout 1000000 ticks).
`timescale 1ns / 1ps
`default_nettype none
module pulse_train_capture import ptc_pkg::*; #(
  parameter int MAX_PULSES = 256
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic               opcode,
  input  wire logic               pin_level,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic                    drive_enable,
  output logic                    drive_level,
  output logic                    pulse_valid,
  output logic [31:0]             pulse_width,
  output logic [7:0]              pulse_number,
  output logic                    done_res,
  output logic                    no_pulses,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [CfgIdxW-1:0] cfg_index,
  input  wire logic [31:0]        cfg_data
);

  ptc_cfg_t    cfg;
  ptc_result_t res;
  ptc_result_t out_reg;

  logic s1_valid;
  logic s1_opcode;
  logic s1_level;
  logic advance;

  assign cfg_ready = 1'b1;
  assign advance   = !out_valid || out_ready;
  assign in_ready  = !s1_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.reset_ticks   <= '0;
      cfg.reset_level   <= 1'b0;
      cfg.pulse_limit   <= PULSE_LIMIT_RESET;
      cfg.timeout_ticks <= TIMEOUT_TICKS_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_RESET_TICKS:   cfg.reset_ticks   <= cfg_data;
        REG_RESET_LEVEL:   cfg.reset_level   <= cfg_data[0];
        REG_PULSE_LIMIT:   cfg.pulse_limit   <= cfg_data[8:0];
        REG_TIMEOUT_TICKS: cfg.timeout_ticks <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
    if (in_valid && in_ready) begin
      s1_opcode <= opcode;
      s1_level  <= pin_level;
    end
  end

  ptc_engine #(
    .MAX_PULSES(MAX_PULSES)
  ) u_engine (
    .clk    (clk),
    .rst    (rst),
    .step   (s1_valid && advance),
    .opcode (s1_opcode),
    .level  (s1_level),
    .cfg    (cfg),
    .res    (res)
  );

  // Output register; hold while the receiver stalls.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= s1_valid;
    end
    if (advance && s1_valid) begin
      out_reg <= res;
    end
  end

  assign drive_enable = out_reg.drive_enable;
  assign drive_level  = out_reg.drive_level;
  assign pulse_valid  = out_reg.pulse_valid;
  assign pulse_width  = out_reg.pulse_width;
  assign pulse_number = out_reg.pulse_number;
  assign done_res     = out_reg.done_res;
  assign no_pulses    = out_reg.no_pulses;

endmodule
`default_nettype wire

FILE: rtl/ptc_checker.sv
// Port-level checks for the pulse train capture block, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module ptc_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic        drive_enable,
  input wire logic        drive_level,
  input wire logic        pulse_valid,
  input wire logic [31:0] pulse_width,
  input wire logic [7:0]  pulse_number,
  input wire logic        done_res,
  input wire logic        no_pulses
);

  // A stalled output transaction stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(pulse_width) && $stable(done_res))
    else $error("output transaction dropped or changed while stalled");

  // no_pulses only accompanies a finish.
  a_none_with_done: assert property (@(posedge clk) disable iff (rst)
    out_valid && no_pulses |-> done_res && !pulse_valid)
    else $error("no_pulses without done_res or with a pulse");

  // Pulse fields are zero when no pulse is reported.
  a_pulse_fields: assert property (@(posedge clk) disable iff (rst)
    out_valid && !pulse_valid |-> pulse_width == 32'd0 && pulse_number == 8'd0)
    else $error("pulse fields set without pulse_valid");

  // drive_level is only set while driving, and the pin is never driven while capture reports pulses or finishes.
  a_drive_excl: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (!drive_level || drive_enable) &&
      !(drive_enable && (pulse_valid || done_res)))
    else $error("drive controls inconsistent with capture results");

endmodule

bind pulse_train_capture ptc_checker u_ptc_checker (
  .clk          (clk),
  .rst          (rst),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .drive_enable (drive_enable),
  .drive_level  (drive_level),
  .pulse_valid  (pulse_valid),
  .pulse_width  (pulse_width),
  .pulse_number (pulse_number),
  .done_res     (done_res),
  .no_pulses    (no_pulses)
);
`default_nettype wire
